// File: rtl/tmps_pkg.sv
// ============================================================================
// tmps_pkg
// Shared types and constants for the number triangle path sum core.
// ============================================================================
`default_nettype none

package tmps_pkg;

    // result field widths
    localparam int COL_W       = 4;
    localparam int OUT_VALUE_W = 8;
    localparam int TOTAL_W     = 12;

    // row count register
    localparam int ROWS_REG_W = 4;
    localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 4'd10;

    // apb register file
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_ROWS_IN_USE = 1'b0;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT_RD,
        S_INIT_WR,
        S_LEFT,
        S_LOADL,
        S_RD,
        S_CALC,
        S_TR_RD,
        S_TR_OUT
    } tmps_state_t;

endpackage

`default_nettype wire

// File: rtl/triangle_max_path_sum_core.sv
// ============================================================================
// triangle_max_path_sum_core
// Loads a number triangle one cell per request, solves the maximum path sum
// bottom-up with one shared add/compare unit, then emits the best path.
// ============================================================================
// Loading takes one cell per request; busy stays low until the marked cell.
// The solve and path walk keep busy high; path results come out apex first.
// An early marked cell gives one error result the cycle after it, busy stays low.
// Each solve and path step has a read state before its update state, for the registered memory reads.
// Reset clears the sequencer, load count and result strobe; rows_in_use resets to 10.
`default_nettype none

module triangle_max_path_sum_core
    import tmps_pkg::*;
#(
    parameter int ROWS       = 10,
    parameter int VALUE_BITS = 8
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // request channel
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [VALUE_BITS-1:0]  cell_value,
    input  wire logic                   last_cell,
    // result channel
    output logic                        result_strobe,
    output logic [COL_W-1:0]            path_column,
    output logic [OUT_VALUE_W-1:0]      path_value,
    output logic [TOTAL_W-1:0]          best_total,
    output logic                        error,
    output logic                        last_result,
    // apb configuration port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_AW-1:0]      paddr,
    input  wire logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]           prdata,
    output logic                        pready
);

    localparam int CELLS  = ROWS * (ROWS + 1) / 2;
    localparam int CA     = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int CW     = (CNT_W > 8) ? CNT_W : 8;
    localparam int SA     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IW     = (SA > ROWS_REG_W) ? SA : ROWS_REG_W;
    localparam int SUM_W  = VALUE_BITS + ROWS_REG_W;

    // storage
    logic [VALUE_BITS-1:0] cell_mem   [CELLS];
    logic                  choice_mem [CELLS];
    logic [SUM_W-1:0]      sum_mem    [ROWS];

    // registers
    tmps_state_t            state_reg, state_next;
    logic [ROWS_REG_W-1:0]  rows_in_use_reg, rows_in_use_next;
    logic [CNT_W-1:0]       load_count_reg, load_count_next;
    logic [ROWS_REG_W-1:0]  n_reg, n_next;
    logic [IW-1:0]          row_reg, row_next;
    logic [IW-1:0]          col_reg, col_next;
    logic [CA-1:0]          base_reg, base_next;
    logic [SUM_W-1:0]       left_reg, left_next;
    logic [SUM_W-1:0]       total_reg, total_next;
    logic                   res_strobe_reg, res_strobe_next;
    logic [COL_W-1:0]       res_col_reg, res_col_next;
    logic [OUT_VALUE_W-1:0] res_value_reg, res_value_next;
    logic [TOTAL_W-1:0]     res_total_reg, res_total_next;
    logic                   res_error_reg, res_error_next;
    logic                   res_last_reg, res_last_next;

    // memory read data
    logic [VALUE_BITS-1:0]  cell_rd_reg;
    logic                   choice_rd_reg;
    logic [SUM_W-1:0]       sum_rd_reg;

    // control decode
    logic                   accept;
    logic                   cfg_write;
    logic [ROWS_REG_W-1:0]  n_eff;
    logic [7:0]             needed;
    logic                   store_cell;
    logic [CW-1:0]          count_after;
    logic                   complete;
    logic                   col_at_row;
    logic                   row_zero;
    logic                   trace_last;
    logic [CA-1:0]          cell_addr;
    logic [SA-1:0]          sum_raddr;
    logic                   sum_we;
    logic [SUM_W-1:0]       sum_wdata;
    logic                   pick_right;
    logic [SUM_W-1:0]       best_child;
    logic [SUM_W-1:0]       cell_ext;
    logic [SUM_W-1:0]       node_sum;
    logic [VALUE_BITS+OUT_VALUE_W-1:0] value_ext;
    logic [SUM_W+TOTAL_W-1:0]          total_ext;
    logic [7:0]             n_prod;

    assign accept    = start && (state_reg == S_IDLE);
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == REG_ROWS_IN_USE);

    // effective row count, clamped to 1..ROWS
    always_comb
    begin
        priority if (rows_in_use_reg == '0)
            n_eff = ROWS_REG_W'(1);
        else if (32'(rows_in_use_reg) > ROWS)
            n_eff = ROWS_REG_W'(ROWS);
        else
            n_eff = rows_in_use_reg;
    end

    // cells needed for a full triangle
    assign n_prod      = 8'(n_eff) * (8'(n_eff) + 8'd1);
    assign needed      = n_prod >> 1;
    assign store_cell  = CW'(load_count_reg) < CW'(needed);
    assign count_after = CW'(load_count_reg) + CW'(store_cell);
    assign complete    = count_after >= CW'(needed);

    // loop position decode
    assign col_at_row = (col_reg == row_reg);
    assign row_zero   = (row_reg == '0);
    assign trace_last = (row_reg == IW'(n_reg) - IW'(1));

    // memory addressing
    assign cell_addr = base_reg + CA'(col_reg);
    assign sum_raddr = col_reg[SA-1:0] + SA'(state_reg == S_RD);

    // shared add/compare unit
    assign pick_right = !(left_reg >= sum_rd_reg);
    assign best_child = pick_right ? sum_rd_reg : left_reg;
    assign cell_ext   = SUM_W'(cell_rd_reg);
    assign node_sum   = cell_ext + best_child;

    // row-sum write port
    assign sum_we    = (state_reg == S_INIT_WR) || (state_reg == S_CALC);
    assign sum_wdata = (state_reg == S_CALC) ? node_sum : cell_ext;

    // output field extension
    assign value_ext = {{OUT_VALUE_W{1'b0}}, cell_rd_reg};
    assign total_ext = {{TOTAL_W{1'b0}}, total_reg};

    // cell memory
    always_ff @(posedge clk)
    begin
        if (accept && store_cell)
        begin
            cell_mem[load_count_reg[CA-1:0]] <= cell_value;
        end
        cell_rd_reg <= cell_mem[cell_addr];
    end

    // choice memory
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CALC)
        begin
            choice_mem[cell_addr] <= pick_right;
        end
        choice_rd_reg <= choice_mem[cell_addr];
    end

    // row-sum memory
    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[col_reg[SA-1:0]] <= sum_wdata;
        end
        sum_rd_reg <= sum_mem[sum_raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && last_cell && complete)
                    state_next = S_INIT_RD;
            end
            S_INIT_RD:
                state_next = S_INIT_WR;
            S_INIT_WR:
            begin
                if (col_at_row)
                    state_next = row_zero ? S_TR_RD : S_LEFT;
                else
                    state_next = S_INIT_RD;
            end
            S_LEFT:
                state_next = S_LOADL;
            S_LOADL:
                state_next = S_RD;
            S_RD:
                state_next = S_CALC;
            S_CALC:
            begin
                if (col_at_row)
                    state_next = row_zero ? S_TR_RD : S_LEFT;
                else
                    state_next = S_RD;
            end
            S_TR_RD:
                state_next = S_TR_OUT;
            S_TR_OUT:
                state_next = trace_last ? S_IDLE : S_TR_RD;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and result updates
    always_comb
    begin
        rows_in_use_next = rows_in_use_reg;
        load_count_next  = load_count_reg;
        n_next           = n_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        base_next        = base_reg;
        left_next        = left_reg;
        total_next       = total_reg;
        res_strobe_next  = 1'b0;
        res_col_next     = res_col_reg;
        res_value_next   = res_value_reg;
        res_total_next   = res_total_reg;
        res_error_next   = res_error_reg;
        res_last_next    = res_last_reg;

        if (cfg_write)
            rows_in_use_next = pwdata[ROWS_REG_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (store_cell)
                        load_count_next = load_count_reg + CNT_W'(1);
                    if (last_cell)
                    begin
                        load_count_next = '0;
                        if (complete)
                        begin
                            // start at the bottom row
                            n_next    = n_eff;
                            row_next  = IW'(n_eff) - IW'(1);
                            col_next  = '0;
                            base_next = CA'(needed - 8'(n_eff));
                        end
                        else
                        begin
                            // early last: single error result
                            res_strobe_next = 1'b1;
                            res_col_next    = '0;
                            res_value_next  = '0;
                            res_total_next  = '0;
                            res_error_next  = 1'b1;
                            res_last_next   = 1'b1;
                        end
                    end
                end
            end
            S_INIT_WR:
            begin
                if (col_at_row)
                begin
                    col_next = '0;
                    if (row_zero)
                    begin
                        total_next = cell_ext;
                    end
                    else
                    begin
                        base_next = base_reg - CA'(row_reg);
                        row_next  = row_reg - IW'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + IW'(1);
                end
            end
            S_LOADL:
                left_next = sum_rd_reg;
            S_CALC:
            begin
                // right sum of this cell is the left sum of the next one
                left_next = sum_rd_reg;
                if (col_at_row)
                begin
                    col_next = '0;
                    if (row_zero)
                    begin
                        total_next = node_sum;
                    end
                    else
                    begin
                        base_next = base_reg - CA'(row_reg);
                        row_next  = row_reg - IW'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + IW'(1);
                end
            end
            S_TR_OUT:
            begin
                res_strobe_next = 1'b1;
                res_col_next    = COL_W'(col_reg + IW'(1));
                res_value_next  = value_ext[OUT_VALUE_W-1:0];
                res_total_next  = total_ext[TOTAL_W-1:0];
                res_error_next  = 1'b0;
                res_last_next   = trace_last;
                // step down to the chosen child
                col_next  = col_reg + IW'(choice_rd_reg);
                base_next = base_reg + CA'(row_reg) + CA'(1);
                row_next  = row_reg + IW'(1);
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            rows_in_use_reg <= ROWS_RESET;
            load_count_reg  <= '0;
            res_strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            rows_in_use_reg <= rows_in_use_next;
            load_count_reg  <= load_count_next;
            res_strobe_reg  <= res_strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        base_reg      <= base_next;
        left_reg      <= left_next;
        total_reg     <= total_next;
        res_col_reg   <= res_col_next;
        res_value_reg <= res_value_next;
        res_total_reg <= res_total_next;
        res_error_reg <= res_error_next;
        res_last_reg  <= res_last_next;
    end

    // ports
    assign busy          = (state_reg != S_IDLE);
    assign result_strobe = res_strobe_reg;
    assign path_column   = res_col_reg;
    assign path_value    = res_value_reg;
    assign best_total    = res_total_reg;
    assign error         = res_error_reg;
    assign last_result   = res_last_reg;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_ROWS_IN_USE)
                           ? {{(APB_DW-ROWS_REG_W){1'b0}}, rows_in_use_reg}
                           : '0;

endmodule

`default_nettype wire

// File: rtl/tmps_checker.sv
// ============================================================================
// tmps_checker
// Port-level checks on the result stream of the triangle path sum core.
// ============================================================================
`default_nettype none

module tmps_checker
    import tmps_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   start,
    input wire logic                   busy,
    input wire logic                   last_cell,
    input wire logic                   result_strobe,
    input wire logic [COL_W-1:0]       path_column,
    input wire logic [TOTAL_W-1:0]     best_total,
    input wire logic                   error,
    input wire logic                   last_result
);

    // an error result closes the request and carries no path
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && error) |-> (last_result && path_column == '0
                                      && best_total == '0))
    else $error("error result malformed");

    // a path result always names a column from 1
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !error) |-> (path_column != '0))
    else $error("path result with column zero");

    // more path results follow, so the core stays busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !last_result) |-> busy)
    else $error("idle before final path result");

    // the next path result follows the core's next read state, with the same total
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !last_result) |-> ##2
            (result_strobe && best_total == $past(best_total, 2)))
    else $error("path results broken or total changed");

    // an unmarked cell request produces no result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !last_cell) |=> !result_strobe)
    else $error("result without marked cell");

endmodule

bind triangle_max_path_sum_core tmps_checker u_tmps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .last_cell     (last_cell),
    .result_strobe (result_strobe),
    .path_column   (path_column),
    .best_total    (best_total),
    .error         (error),
    .last_result   (last_result)
);

`default_nettype wire
